FILE: rtl/bmp_pixel_to_tricolor_unit_assert.svh
// Assertion macros used by the top level of the BMP to three-colour pixel unit.
`ifndef BMP_PIXEL_TO_TRICOLOR_UNIT_ASSERT_SVH
`define BMP_PIXEL_TO_TRICOLOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BMPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmpt: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define BMPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmpt: next-cycle check failed");

`endif

FILE: rtl/bmpt_pkg.sv
// Shared types and constants of the BMP to three-colour pixel unit.
package bmpt_pkg;

    localparam int MAX_ROW_PIXELS      = 640;
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int COL_W               = 10;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [1:0] COLOR_WHITE   = 2'd0;
    localparam logic [1:0] COLOR_BLACK   = 2'd1;
    localparam logic [1:0] COLOR_COLORED = 2'd2;

    typedef enum logic [1:0] {
        CFG_BPP       = 2'd0,
        CFG_USE_565   = 2'd1,
        CFG_COLOR_EN  = 2'd2,
        CFG_VIS_WIDTH = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        JOB_PAL = 2'd0,
        JOB_IDX = 2'd1,
        JOB_RGB = 2'd2
    } t_job_kind;

    typedef enum logic [1:0] {
        UNP_D1 = 2'd0,
        UNP_D4 = 2'd1,
        UNP_D8 = 2'd2
    } t_unpack;

    // One unit of work passed from the front to the back.
    typedef struct packed {
        t_job_kind        kind;
        t_unpack          unpack;
        logic             eff;
        logic [7:0]       data;
        logic             white;
        logic             colored;
        logic [2:0]       count_m1;
        logic [COL_W-1:0] col;
    } t_job;

endpackage

FILE: rtl/bmp_pixel_to_tricolor_unit.sv
// Top level of the BMP row byte to three-colour e-paper pixel unit.
// The unit takes one request per cycle while its four-entry job queue has room: a palette load
// or one byte of row data. A byte yields eight pixels at depth 1, two at depth 4 and one at
// depth 8; at depths 16 and 24 only the byte that completes a pixel yields one. The back end
// emits one pixel per cycle while i_out_ready stays high, so depths 8, 16 and 24 sustain one
// byte per cycle. A byte's job passes through the queue, the registered palette read and the
// output register before its pixels are offered on the output. Pixels at or beyond the
// visible width are dropped and the last pixel of a byte carries o_last. Configuration is to
// be written only while the unit is idle, which the unit itself does not enforce; the palette
// needs no clearing pass, but an entry must be loaded before a pixel refers to it.
`include "bmp_pixel_to_tricolor_unit_assert.svh"

module bmp_pixel_to_tricolor_unit #(
    parameter int PALETTE_ENTRIES = bmpt_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [bmpt_pkg::COL_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_mode,
    input  logic [7:0]                 i_palette_index,
    input  logic [7:0]                 i_pal_red,
    input  logic [7:0]                 i_pal_green,
    input  logic [7:0]                 i_pal_blue,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_row_start,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_pixel_color,
    output logic [bmpt_pkg::COL_W-1:0] o_column,
    output logic                       o_last
);

    logic           w_push;
    bmpt_pkg::t_job w_job;
    logic           w_full;
    logic           w_pop;
    bmpt_pkg::t_job w_head;
    logic           w_empty;

    logic                       w_out_take;
    logic [bmpt_pkg::COL_W-1:0] w_col_next;
    logic                       w_color_ok;

    bmpt_front #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_palette_index (i_palette_index),
        .i_pal_red       (i_pal_red),
        .i_pal_green     (i_pal_green),
        .i_pal_blue      (i_pal_blue),
        .i_data_byte     (i_data_byte),
        .i_row_start     (i_row_start),
        .o_push          (w_push),
        .o_job           (w_job),
        .i_full          (w_full)
    );

    bmpt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_job),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_empty    (w_empty)
    );

    bmpt_back #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_color (o_pixel_color),
        .o_column      (o_column),
        .o_last        (o_last)
    );

    assign w_out_take = o_out_valid && i_out_ready;
    assign w_col_next = o_column + bmpt_pkg::COL_W'(1);
    assign w_color_ok = (o_pixel_color == bmpt_pkg::COLOR_WHITE) ||
                        (o_pixel_color == bmpt_pkg::COLOR_BLACK) ||
                        (o_pixel_color == bmpt_pkg::COLOR_COLORED);

    // The front never offers a job that the queue cannot hold.
    `BMPT_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, w_push, !w_full)

    // The back only retires a job that is present.
    `BMPT_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, w_pop, !w_empty)

    // Within one byte the pixels follow each other without a gap, one column apart.
    `BMPT_ASSERT_NEXT(a_byte_columns, i_clk, i_rst_n, w_out_take && !o_last,
                      o_out_valid && (o_column == $past(w_col_next)))

    // Only the three defined colour codes reach the output.
    `BMPT_ASSERT_SAME(a_color_code, i_clk, i_rst_n, o_out_valid, w_color_ok)

endmodule

FILE: rtl/bmpt_front.sv
// Front end: configuration registers, request acceptance, unpacking and column accounting.
module bmpt_front #(
    parameter int PALETTE_ENTRIES = bmpt_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [bmpt_pkg::COL_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_mode,
    input  logic [7:0]                 i_palette_index,
    input  logic [7:0]                 i_pal_red,
    input  logic [7:0]                 i_pal_green,
    input  logic [7:0]                 i_pal_blue,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_row_start,
    output logic                       o_push,
    output bmpt_pkg::t_job             o_job,
    input  logic                       i_full
);

    localparam int CW = bmpt_pkg::COL_W;

    logic [4:0]    r_bpp;
    logic          r_use_565;
    logic          r_color_en;
    logic [CW-1:0] r_vis_width;
    logic [15:0]   r_held, n_held;
    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_col, n_col;

    logic          accept;
    logic          eff;
    logic [CW-1:0] limit;
    logic [CW-1:0] col0;
    logic [1:0]    ph0;
    logic [15:0]   held0;
    logic [CW-1:0] avail;
    logic [3:0]    npix;
    logic [3:0]    cnt;
    logic [7:0]    px_r, px_g, px_b;

    function automatic logic f_whitish(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic e);
        logic [9:0] sum;
        sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
        if (e)
            return (r > 8'h80) && (g > 8'h80) && (b > 8'h80);
        return sum > 10'd384;
    endfunction

    function automatic logic f_colored(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
        return (r > 8'hF0) || ((g > 8'hF0) && (b > 8'hF0));
    endfunction

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_full;
    assign accept      = i_in_valid && o_in_ready;
    assign eff         = r_color_en && (r_bpp != 5'd1);

    always_comb begin
        if (32'(r_vis_width) > bmpt_pkg::MAX_ROW_PIXELS) begin
            limit = CW'(bmpt_pkg::MAX_ROW_PIXELS);
        end else begin
            limit = r_vis_width;
        end
    end

    always_comb begin
        n_held  = r_held;
        n_phase = r_phase;
        n_col   = r_col;
        o_push  = 1'b0;
        o_job   = '0;
        npix    = 4'd0;
        cnt     = 4'd0;
        avail   = '0;
        px_r    = 8'h00;
        px_g    = 8'h00;
        px_b    = 8'h00;
        col0    = i_row_start ? '0 : r_col;
        ph0     = i_row_start ? 2'd0 : r_phase;
        held0   = i_row_start ? 16'h0000 : r_held;
        o_job.eff = eff;
        if (accept) begin
            if (!i_mode) begin
                if ({1'b0, i_palette_index} < 9'(PALETTE_ENTRIES)) begin
                    o_push        = 1'b1;
                    o_job.kind    = bmpt_pkg::JOB_PAL;
                    o_job.data    = i_palette_index;
                    o_job.white   = f_whitish(i_pal_red, i_pal_green, i_pal_blue, eff);
                    o_job.colored = f_colored(i_pal_red, i_pal_green, i_pal_blue);
                end
            end else begin
                n_col      = col0;
                n_phase    = ph0;
                n_held     = held0;
                o_job.data = i_data_byte;
                o_job.kind = bmpt_pkg::JOB_IDX;
                case (r_bpp)
                    5'd1: begin
                        npix         = 4'd8;
                        o_job.unpack = bmpt_pkg::UNP_D1;
                    end
                    5'd4: begin
                        npix         = 4'd2;
                        o_job.unpack = bmpt_pkg::UNP_D4;
                    end
                    5'd8: begin
                        npix         = 4'd1;
                        o_job.unpack = bmpt_pkg::UNP_D8;
                    end
                    5'd16: begin
                        if (ph0 == 2'd0) begin
                            n_held  = {8'h00, i_data_byte};
                            n_phase = 2'd1;
                        end else begin
                            px_b = {held0[4:0], 3'b000};
                            if (r_use_565) begin
                                px_g = {i_data_byte[2:0], held0[7:5], 2'b00};
                                px_r = {i_data_byte[7:3], 3'b000};
                            end else begin
                                px_g = {i_data_byte[1:0], held0[7:5], 3'b000};
                                px_r = {i_data_byte[6:2], 3'b000};
                            end
                            n_held     = 16'h0000;
                            n_phase    = 2'd0;
                            npix       = 4'd1;
                            o_job.kind = bmpt_pkg::JOB_RGB;
                        end
                    end
                    5'd24: begin
                        if (ph0 == 2'd0) begin
                            n_held  = {8'h00, i_data_byte};
                            n_phase = 2'd1;
                        end else if (ph0 == 2'd1) begin
                            n_held  = {i_data_byte, held0[7:0]};
                            n_phase = 2'd2;
                        end else begin
                            px_r       = i_data_byte;
                            px_g       = held0[15:8];
                            px_b       = held0[7:0];
                            n_held     = 16'h0000;
                            n_phase    = 2'd0;
                            npix       = 4'd1;
                            o_job.kind = bmpt_pkg::JOB_RGB;
                        end
                    end
                    default: begin
                        npix = 4'd0;
                    end
                endcase
                o_job.white   = f_whitish(px_r, px_g, px_b, eff);
                o_job.colored = f_colored(px_r, px_g, px_b);
                avail = (col0 < limit) ? (limit - col0) : '0;
                cnt   = (avail < CW'(npix)) ? avail[3:0] : npix;
                if (cnt != 4'd0) begin
                    o_push         = 1'b1;
                    o_job.count_m1 = 3'(cnt - 4'd1);
                    o_job.col      = col0;
                    n_col          = col0 + CW'(cnt);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp       <= 5'd24;
            r_use_565   <= 1'b0;
            r_color_en  <= 1'b1;
            r_vis_width <= CW'(296);
            r_held      <= 16'h0000;
            r_phase     <= 2'd0;
            r_col       <= '0;
        end else begin
            r_held  <= n_held;
            r_phase <= n_phase;
            r_col   <= n_col;
            if (i_cfg_valid && o_cfg_ready) begin
                case (bmpt_pkg::t_cfg_index'(i_cfg_index))
                    bmpt_pkg::CFG_BPP:       r_bpp       <= i_cfg_data[4:0];
                    bmpt_pkg::CFG_USE_565:   r_use_565   <= i_cfg_data[0];
                    bmpt_pkg::CFG_COLOR_EN:  r_color_en  <= i_cfg_data[0];
                    bmpt_pkg::CFG_VIS_WIDTH: r_vis_width <= i_cfg_data;
                    default: begin
                        r_bpp <= r_bpp;
                    end
                endcase
            end
        end
    end

endmodule

FILE: rtl/bmpt_queue.sv
// Short job queue that decouples the front end from the pixel back end.
module bmpt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmpt_pkg::t_job i_push_job,
    output logic           o_full,
    input  logic           i_pop,
    output bmpt_pkg::t_job o_head,
    output logic           o_empty
);

    localparam int DEPTH = bmpt_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    bmpt_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [NW-1:0]  r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + NW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

FILE: rtl/bmpt_back.sv
// Back end: palette store, per-pixel serialiser and the registered output stage.
module bmpt_back #(
    parameter int PALETTE_ENTRIES = bmpt_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bmpt_pkg::t_job             i_head,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_pixel_color,
    output logic [bmpt_pkg::COL_W-1:0] o_column,
    output logic                       o_last
);

    localparam int CW = bmpt_pkg::COL_W;
    localparam int IW = $clog2(PALETTE_ENTRIES);

    logic [1:0]    r_pal [PALETTE_ENTRIES];
    logic [1:0]    r_rd;
    logic [2:0]    r_k;
    logic          r_s1_valid;
    logic          r_s1_idx;
    logic          r_s1_oor;
    logic          r_s1_white;
    logic          r_s1_colored;
    logic          r_s1_eff;
    logic [CW-1:0] r_s1_col;
    logic          r_s1_last;
    logic          r_o_valid;
    logic [1:0]    r_o_color;
    logic [CW-1:0] r_o_col;
    logic          r_o_last;

    logic          adv;
    logic          head_pal;
    logic          head_pix;
    logic          issue;
    logic          is_last;
    logic [7:0]    idx8;
    logic          oor;
    logic [IW-1:0] addr;
    logic          sel_white;
    logic          sel_colored;
    logic [1:0]    code;

    assign adv      = !r_o_valid || i_out_ready;
    assign head_pal = !i_empty && (i_head.kind == bmpt_pkg::JOB_PAL);
    assign head_pix = !i_empty && (i_head.kind != bmpt_pkg::JOB_PAL);
    assign issue    = head_pix && adv;
    assign is_last  = (r_k == i_head.count_m1);
    assign o_pop    = head_pal || (issue && is_last);

    always_comb begin
        case (i_head.unpack)
            bmpt_pkg::UNP_D1: idx8 = {7'b0000000, i_head.data[3'd7 - r_k]};
            bmpt_pkg::UNP_D4: idx8 = r_k[0] ? {4'h0, i_head.data[3:0]}
                                            : {4'h0, i_head.data[7:4]};
            bmpt_pkg::UNP_D8: idx8 = i_head.data;
            default:          idx8 = i_head.data;
        endcase
    end

    assign oor  = ({1'b0, idx8} >= 9'(PALETTE_ENTRIES));
    assign addr = idx8[IW-1:0];

    // A palette index past the store reads as black, as does an entry with both bits clear.
    always_comb begin
        if (r_s1_idx) begin
            sel_white   = !r_s1_oor && r_rd[1];
            sel_colored = !r_s1_oor && r_rd[0];
        end else begin
            sel_white   = r_s1_white;
            sel_colored = r_s1_colored;
        end
        if (sel_white) begin
            code = bmpt_pkg::COLOR_WHITE;
        end else if (sel_colored && r_s1_eff) begin
            code = bmpt_pkg::COLOR_COLORED;
        end else begin
            code = bmpt_pkg::COLOR_BLACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_pal) begin
            r_pal[i_head.data[IW-1:0]] <= {i_head.white, i_head.colored};
        end
        if (issue && (i_head.kind == bmpt_pkg::JOB_IDX)) begin
            r_rd <= r_pal[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_idx     <= (i_head.kind == bmpt_pkg::JOB_IDX);
            r_s1_oor     <= oor;
            r_s1_white   <= i_head.white;
            r_s1_colored <= i_head.colored;
            r_s1_eff     <= i_head.eff;
            r_s1_col     <= i_head.col + CW'(r_k);
            r_s1_last    <= is_last;
        end
        if (adv && r_s1_valid) begin
            r_o_color <= code;
            r_o_col   <= r_s1_col;
            r_o_last  <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k        <= 3'd0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid <= issue;
                r_o_valid  <= r_s1_valid;
            end
            if (issue) begin
                r_k <= is_last ? 3'd0 : r_k + 3'd1;
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_pixel_color = r_o_color;
    assign o_column      = r_o_col;
    assign o_last        = r_o_last;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the BMP row byte to three-colour pixel unit.
module tb_top;

    localparam int   CW               = bmpt_pkg::COL_W;
    localparam int   PAL_N            = bmpt_pkg::PALETTE_ENTRIES_DEF;
    localparam int   HOLD_CYCLES      = 300;
    localparam int   SETTLE_CYCLES    = 8;
    localparam int   SHOWN_MISMATCHES = 10;
    localparam logic MODE_PALETTE     = 1'b0;
    localparam logic MODE_PIXEL       = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] pal_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] data;
        logic       row_start;
    } t_request;

    typedef struct packed {
        logic [1:0]    color;
        logic [CW-1:0] column;
        logic          last;
    } t_pixel;

    logic          i_clk           = 1'b0;
    logic          i_rst_n         = 1'b0;
    logic          i_cfg_valid     = 1'b0;
    logic [1:0]    i_cfg_index     = '0;
    logic [CW-1:0] i_cfg_data      = '0;
    logic          i_in_valid      = 1'b0;
    logic          i_mode          = 1'b0;
    logic [7:0]    i_palette_index = '0;
    logic [7:0]    i_pal_red       = '0;
    logic [7:0]    i_pal_green     = '0;
    logic [7:0]    i_pal_blue      = '0;
    logic [7:0]    i_data_byte     = '0;
    logic          i_row_start     = 1'b0;
    logic          i_out_ready     = 1'b0;
    logic          o_cfg_ready;
    logic          o_in_ready;
    logic          o_out_valid;
    logic [1:0]    o_pixel_color;
    logic [CW-1:0] o_column;
    logic          o_last;

    bmp_pixel_to_tricolor_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_palette_index(i_palette_index),
        .i_pal_red      (i_pal_red),
        .i_pal_green    (i_pal_green),
        .i_pal_blue     (i_pal_blue),
        .i_data_byte    (i_data_byte),
        .i_row_start    (i_row_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_color  (o_pixel_color),
        .o_column       (o_column),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Requests waiting to be offered, and pixels owed by accepted requests.
    t_request req_queue[$];
    t_request on_bus;
    t_pixel   due_pixels[$];
    t_pixel   byte_pixels[$];

    int issued_count   = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int fail_count     = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_count     = 0;
    bit hold_request   = 1'b0;

    // Converter state as the bench sees it.
    logic          pal_white[PAL_N];
    logic          pal_vivid[PAL_N];
    bit            pal_loaded[PAL_N];
    logic [15:0]   pend_bytes;
    logic [1:0]    pend_phase;
    logic [CW-1:0] next_col;
    logic [4:0]    cfg_depth;
    logic          cfg_565;
    logic          cfg_colour;
    logic [9:0]    cfg_width;

    function automatic bit colour_on();
        return cfg_colour && cfg_depth != 5'd1;
    endfunction

    function automatic bit whitish(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [9:0] sum;
        sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
        if (colour_on())
            return r > 8'h80 && g > 8'h80 && b > 8'h80;
        return sum > 10'd384;
    endfunction

    function automatic bit vivid(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return r > 8'hF0 || (g > 8'hF0 && b > 8'hF0);
    endfunction

    function automatic void place_pixel(bit white, bit colored);
        t_pixel      px;
        int unsigned lim;
        lim = (32'(cfg_width) > bmpt_pkg::MAX_ROW_PIXELS) ? bmpt_pkg::MAX_ROW_PIXELS
                                                           : 32'(cfg_width);
        if (32'(next_col) >= lim)
            return;
        if (white)
            px.color = bmpt_pkg::COLOR_WHITE;
        else if (colored && colour_on())
            px.color = bmpt_pkg::COLOR_COLORED;
        else
            px.color = bmpt_pkg::COLOR_BLACK;
        px.column = next_col;
        px.last   = 1'b0;
        byte_pixels.push_back(px);
        next_col = next_col + CW'(1);
    endfunction

    function automatic void place_index(logic [7:0] idx);
        place_pixel(pal_white[idx], pal_vivid[idx]);
    endfunction

    function automatic void place_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        place_pixel(whitish(r, g, b), vivid(r, g, b));
    endfunction

    // Works out the pixels that one accepted request must produce.
    function automatic void convert_request(t_request rq);
        int unsigned lsb, msb, r, g, b;
        int          k;
        byte_pixels.delete();
        if (rq.mode == MODE_PALETTE) begin
            pal_white[rq.pal_index] = whitish(rq.red, rq.green, rq.blue);
            pal_vivid[rq.pal_index] = vivid(rq.red, rq.green, rq.blue);
            return;
        end
        if (rq.row_start) begin
            next_col   = '0;
            pend_phase = 2'd0;
            pend_bytes = 16'h0000;
        end
        case (cfg_depth)
            5'd1: begin
                for (k = 7; k >= 0; k--)
                    place_index({7'b0000000, rq.data[k]});
            end
            5'd4: begin
                place_index({4'h0, rq.data[7:4]});
                place_index({4'h0, rq.data[3:0]});
            end
            5'd8: place_index(rq.data);
            5'd16: begin
                if (pend_phase == 2'd0) begin
                    pend_bytes = {8'h00, rq.data};
                    pend_phase = 2'd1;
                end else begin
                    lsb = 32'(pend_bytes[7:0]);
                    msb = 32'(rq.data);
                    b   = (lsb & 'h1F) << 3;
                    if (cfg_565) begin
                        g = ((msb & 'h07) << 5) | ((lsb & 'hE0) >> 3);
                        r = msb & 'hF8;
                    end else begin
                        g = ((msb & 'h03) << 6) | ((lsb & 'hE0) >> 2);
                        r = (msb & 'h7C) << 1;
                    end
                    pend_phase = 2'd0;
                    pend_bytes = 16'h0000;
                    place_rgb(8'(r), 8'(g), 8'(b));
                end
            end
            5'd24: begin
                if (pend_phase == 2'd0) begin
                    pend_bytes = {8'h00, rq.data};
                    pend_phase = 2'd1;
                end else if (pend_phase == 2'd1) begin
                    pend_bytes[15:8] = rq.data;
                    pend_phase       = 2'd2;
                end else begin
                    b          = 32'(pend_bytes[7:0]);
                    g          = 32'(pend_bytes[15:8]);
                    pend_phase = 2'd0;
                    pend_bytes = 16'h0000;
                    place_rgb(rq.data, 8'(g), 8'(b));
                end
            end
            default: ;
        endcase
        if (byte_pixels.size() != 0)
            byte_pixels[byte_pixels.size() - 1].last = 1'b1;
        foreach (byte_pixels[i])
            due_pixels.push_back(byte_pixels[i]);
    endfunction

    // Request driver: offers queued requests, with random gaps between them.
    always @(posedge i_clk) begin : request_driver
        t_request nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                convert_request(on_bus);
                accepted_count++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = req_queue.pop_front();
                    on_bus          <= nxt;
                    i_mode          <= nxt.mode;
                    i_palette_index <= nxt.pal_index;
                    i_pal_red       <= nxt.red;
                    i_pal_green     <= nxt.green;
                    i_pal_blue      <= nxt.blue;
                    i_data_byte     <= nxt.data;
                    i_row_start     <= nxt.row_start;
                    i_in_valid      <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor: checks each accepted pixel and drives the output ready.
    always @(posedge i_clk) begin : pixel_monitor
        t_pixel want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                checked_count++;
                if (due_pixels.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOWN_MISMATCHES)
                        $display("unexpected pixel: colour %0d column %0d last %0d",
                                 o_pixel_color, o_column, o_last);
                end else begin
                    want = due_pixels.pop_front();
                    if (o_pixel_color !== want.color || o_column !== want.column ||
                        o_last !== want.last) begin
                        fail_count++;
                        if (fail_count <= SHOWN_MISMATCHES)
                            $display("pixel mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.color, want.column, want.last,
                                     o_pixel_color, o_column, o_last);
                    end
                end
            end
            // The long hold-off keeps ready low while requests pile up behind it.
            if (hold_request && hold_count < HOLD_CYCLES) begin
                i_out_ready <= 1'b0;
                hold_count  <= hold_count + 1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [7:0] chan_value();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'h80;
            2: return 8'h81;
            3: return 8'hF0;
            4: return 8'hF1;
            5: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void load_entry(int unsigned idx, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b);
        t_request rq;
        rq.mode      = MODE_PALETTE;
        rq.pal_index = idx[7:0];
        rq.red       = r;
        rq.green     = g;
        rq.blue      = b;
        rq.data      = 8'($urandom_range(255));
        rq.row_start = 1'($urandom_range(1));
        req_queue.push_back(rq);
        pal_loaded[idx[7:0]] = 1'b1;
        issued_count++;
    endfunction

    function automatic void send_byte(logic [7:0] d, logic rs);
        t_request rq;
        rq.mode      = MODE_PIXEL;
        rq.pal_index = 8'($urandom_range(255));
        rq.red       = 8'($urandom_range(255));
        rq.green     = 8'($urandom_range(255));
        rq.blue      = 8'($urandom_range(255));
        rq.data      = d;
        rq.row_start = rs;
        req_queue.push_back(rq);
        issued_count++;
    endfunction

    // Only entries that have been loaded may be referred to by a pixel.
    function automatic logic [7:0] pick_entry(int unsigned bound);
        int unsigned i;
        do i = $urandom_range(bound - 1); while (!pal_loaded[i[7:0]]);
        return i[7:0];
    endfunction

    function automatic logic [7:0] pixel_byte(int depth);
        logic [7:0] hi, lo;
        case (depth)
            1: return 8'($urandom_range(255));
            4: begin
                hi = pick_entry(16);
                lo = pick_entry(16);
                return {hi[3:0], lo[3:0]};
            end
            8: return pick_entry(256);
            default: return ($urandom_range(1) != 0) ? chan_value() : 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly whole rows of whole pixels, with palette loads, a few broken rows and stray row starts.
    function automatic void fill_rows(int depth, int n);
        int made, span, run, k;
        made = 0;
        span = (depth == 24) ? 3 : (depth == 16) ? 2 : 1;
        while (made < n) begin
            if ($urandom_range(9) == 0) begin
                load_entry(($urandom_range(1) != 0) ? $urandom_range(15) : $urandom_range(255),
                           chan_value(), chan_value(), chan_value());
                made++;
            end else begin
                run = span * $urandom_range(1, 6);
                if ($urandom_range(9) == 0)
                    run = $urandom_range(1, 7);
                if (run > n - made)
                    run = n - made;
                for (k = 0; k < run; k++)
                    send_byte(pixel_byte(depth), (k == 0) ? ($urandom_range(19) != 0)
                                                          : ($urandom_range(29) == 0));
                made += run;
            end
        end
    endfunction

    task automatic settle();
        while (accepted_count != issued_count || due_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(bmpt_pkg::t_cfg_index idx, int unsigned value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CW-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            bmpt_pkg::CFG_BPP:       cfg_depth  = value[4:0];
            bmpt_pkg::CFG_USE_565:   cfg_565    = value[0];
            bmpt_pkg::CFG_COLOR_EN:  cfg_colour = value[0];
            bmpt_pkg::CFG_VIS_WIDTH: cfg_width  = value[9:0];
            default: ;
        endcase
    endtask

    // Palette loads give no pixel, so the bench also waits out SETTLE_CYCLES before the unit counts as idle.
    task automatic configure(int depth, bit use565, bit colour, int width);
        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(bmpt_pkg::CFG_BPP, depth);
        write_reg(bmpt_pkg::CFG_USE_565, use565);
        write_reg(bmpt_pkg::CFG_COLOR_EN, colour);
        write_reg(bmpt_pkg::CFG_VIS_WIDTH, width);
    endtask

    task automatic run_phase(int depth, bit use565, bit colour, int width, int n,
                             int idle_pct, int stall, bit long_hold);
        configure(depth, use565, colour, width);
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        if (long_hold)
            hold_request <= 1'b1;
        fill_rows(depth, n / 2);
        // The sender waits here until every pixel owed so far has come out.
        settle();
        fill_rows(depth, n - n / 2);
    endtask

    initial begin : stimulus
        int k;
        foreach (pal_white[i]) begin
            pal_white[i]  = 1'b0;
            pal_vivid[i]  = 1'b0;
            pal_loaded[i] = 1'b0;
        end
        pend_bytes = 16'h0000;
        pend_phase = 2'd0;
        next_col   = '0;
        cfg_depth  = 5'd24;
        cfg_565    = 1'b0;
        cfg_colour = 1'b1;
        cfg_width  = 10'd296;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset settings: palette extremes and 24-bit pixels.
        load_entry(0, 8'hFF, 8'hFF, 8'hFF);
        load_entry(1, 8'h00, 8'h00, 8'h00);
        load_entry(2, 8'hF1, 8'h00, 8'h00);
        load_entry(3, 8'h00, 8'hF1, 8'hF1);
        load_entry(4, 8'h80, 8'hFF, 8'hFF);
        load_entry(255, 8'h81, 8'h81, 8'h81);
        send_byte(8'hFF, 1'b1); send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'hF1, 1'b0);
        send_byte(8'hF1, 1'b0); send_byte(8'hF1, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h81, 1'b0); send_byte(8'h80, 1'b0); send_byte(8'h81, 1'b0);
        // A lone byte of a pixel, then a row start that discards it.
        send_byte(8'h12, 1'b0);
        send_byte(8'hF0, 1'b1); send_byte(8'hF0, 1'b0); send_byte(8'hF0, 1'b0);

        run_phase(8, 1'b0, 1'b1, 296, 20, 0, 0, 1'b0);
        run_phase(4, 1'b0, 1'b1, 5, 20, 49, 0, 1'b0);
        run_phase(16, 1'b0, 1'b1, 296, 20, 0, 49, 1'b0);
        run_phase(16, 1'b1, 1'b0, 1023, 20, 30, 30, 1'b0);
        run_phase(1, 1'b0, 1'b1, 13, 20, 0, 0, 1'b1);
        run_phase(24, 1'b0, 1'b0, 1, 20, 49, 49, 1'b0);
        run_phase(0, 1'b1, 1'b1, 296, 10, 0, 0, 1'b0);
        run_phase(31, 1'b0, 1'b0, 640, 10, 0, 0, 1'b0);
        run_phase(12, 1'b0, 1'b1, 296, 10, 0, 0, 1'b0);

        // One row longer than the widest the unit will emit.
        configure(1, 1'b0, 1'b0, 1023);
        send_idle_pct = 0;
        stall_pct     = 0;
        send_byte(8'($urandom_range(255)), 1'b1);
        for (k = 0; k < 84; k++)
            send_byte(8'($urandom_range(255)), 1'b0);

        run_phase(24, 1'b0, 1'b1, 640, 20, 30, 30, 1'b0);
        run_phase(8, 1'b0, 1'b0, 2, 20, 49, 0, 1'b0);

        settle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests and checked %0d pixels over depths 1, 4, 8, 16 and 24,",
                 accepted_count, checked_count);
        $display("both 16-bit layouts, colour on and off, clipped rows and invalid depths.");
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: bmp_pixel_to_tricolor_unit.f
+incdir+rtl
rtl/bmpt_pkg.sv
rtl/bmpt_front.sv
rtl/bmpt_queue.sv
rtl/bmpt_back.sv
rtl/bmp_pixel_to_tricolor_unit.sv
bench/tb_top.sv
